@@ design/hbp_pkg.sv @@
// Package for the Huffman bit packer: field widths, item mode codes,
// sequencer states and the control/status structs shared by the modules.
// No dependencies.
`default_nettype none

package hbp_pkg;

  localparam int ModeW   = 2;
  localparam int SymW    = 8;
  localparam int CodeW   = 32;
  localparam int LenW    = 6;
  localparam int ByteW   = 8;
  localparam int TotalW  = 32;
  // pending byte plus the longest code
  localparam int WorkW   = ByteW + CodeW;

  localparam logic [ModeW-1:0] MODE_LOAD   = 2'd0;
  localparam logic [ModeW-1:0] MODE_ENCODE = 2'd1;
  localparam logic [ModeW-1:0] MODE_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT,
    ST_FLUSH
  } hbp_state_t;

  typedef struct packed {
    logic start;  // merge looked-up code with pending bits
    logic step;   // hand out the head byte
    logic clear;  // drop pending bits
  } hbp_pack_ctl_t;

  typedef struct packed {
    logic [ByteW-1:0] head;
    logic [2:0]       remaining;
    logic [ByteW-1:0] pending;
    logic [2:0]       pending_count;
  } hbp_pack_stat_t;

endpackage

`default_nettype wire

@@ design/hbp_if.sv @@
// Valid/ready channel interfaces for the bit packer: input items and result items.
// Depends on hbp_pkg.
`default_nettype none

interface hbp_in_if;
  import hbp_pkg::*;
  logic                valid;
  logic                ready;
  logic [ModeW-1:0]    mode;
  logic [SymW-1:0]     symbol;
  logic [CodeW-1:0]    code_bits;
  logic [LenW-1:0]     code_length;

  modport source (output valid, mode, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, mode, symbol, code_bits, code_length, output ready);
endinterface

interface hbp_out_if;
  import hbp_pkg::*;
  logic                valid;
  logic                ready;
  logic [ByteW-1:0]    out_byte;
  logic                byte_valid;
  logic [TotalW-1:0]   symbol_total;
  logic                last;

  modport source (output valid, out_byte, byte_valid, symbol_total, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, symbol_total, last, output ready);
endinterface

`default_nettype wire

@@ design/hbp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/hbp_packer.sv @@
// Bit packing datapath: pending partial byte plus a left-aligned work word
// that is handed out one byte per step. Depends on hbp_pkg.
`default_nettype none

module hbp_packer (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire hbp_pkg::hbp_pack_ctl_t  ctl,
  input  wire logic [hbp_pkg::CodeW-1:0] code,
  input  wire logic [hbp_pkg::LenW-1:0]  len,
  output hbp_pkg::hbp_pack_stat_t      stat
);
  import hbp_pkg::*;

  logic [ByteW-1:0] pending;
  logic [2:0]       pending_count;
  logic [WorkW-1:0] work;
  logic [2:0]       remaining;

  logic [CodeW-1:0] code_left;
  logic [WorkW-1:0] merged;
  logic [LenW-1:0]  total;

  // Pending bits are kept left-aligned, so a flush needs no padding shift.
  always_comb begin
    code_left = code << (LenW'(CodeW) - len);
    merged    = {pending, {CodeW{1'b0}}} | ({code_left, {ByteW{1'b0}}} >> pending_count);
    total     = LenW'(pending_count) + len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= '0;
      pending_count <= '0;
      remaining     <= '0;
    end else if (ctl.clear) begin
      pending       <= '0;
      pending_count <= '0;
    end else if (ctl.start) begin
      work          <= merged;
      remaining     <= total[5:3];
      pending       <= merged[WorkW-1 -: ByteW];
      pending_count <= total[2:0];
    end else if (ctl.step) begin
      work      <= work << ByteW;
      remaining <= remaining - 3'd1;
      // head after the shift; correct once the last full byte has left
      pending   <= work[WorkW-ByteW-1 -: ByteW];
    end
  end

  assign stat.head          = work[WorkW-1 -: ByteW];
  assign stat.remaining     = remaining;
  assign stat.pending       = pending;
  assign stat.pending_count = pending_count;

endmodule

`default_nettype wire

@@ design/huffman_bit_packer_unit.sv @@
// Channel  | Dir | Payload                                       | Moves
// req      | in  | mode, symbol, code_bits, code_length          | one item per handshake
// rsp      | out | out_byte, byte_valid, symbol_total, last      | zero to four items per input
//
// One item at a time. A load writes the table at accept. An encode does a table
// read, a merge, then one output byte per cycle from the packer while the
// output register is free. A flush emits the pending bits. The output register
// frees up when rsp takes its item; while it is held the sequencer waits.
// Synchronous reset clears control, valid bits and counters; code RAM is not cleared.
// Depends on hbp_pkg, hbp_if, hbp_ram, hbp_packer.
`default_nettype none

module huffman_bit_packer_unit #(
  parameter int SYMBOLS       = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  hbp_in_if.sink    req,
  hbp_out_if.source rsp
);
  import hbp_pkg::*;

  localparam int AW   = $clog2(SYMBOLS);
  localparam int SLW  = $clog2(MAX_CODE_BITS + 1);
  localparam int RAMW = MAX_CODE_BITS + SLW;

  hbp_state_t state, state_next;

  logic               accept;
  logic               in_range;
  logic [AW-1:0]      addr;
  logic [SYMBOLS-1:0] loaded;
  logic               loaded_q;
  logic [LenW-1:0]    len_clamp;
  logic               ram_we;
  logic               ram_re;
  logic [RAMW-1:0]    ram_wdata;
  logic [RAMW-1:0]    ram_rdata;
  logic [CodeW-1:0]   lk_code;
  logic [LenW-1:0]    lk_len;
  logic [TotalW-1:0]  counter;

  hbp_pack_ctl_t  pctl;
  hbp_pack_stat_t pstat;

  logic              out_valid;
  logic              out_free;
  logic              out_load;
  logic [ByteW-1:0]  out_byte_d;
  logic              byte_valid_d;
  logic [TotalW-1:0] total_d;
  logic              last_d;
  logic [ByteW-1:0]  out_byte;
  logic              byte_valid;
  logic [TotalW-1:0] symbol_total;
  logic              last;

  assign accept   = req.valid && req.ready;
  assign in_range = ({1'b0, req.symbol} < (SymW + 1)'(SYMBOLS));
  assign addr     = req.symbol[AW-1:0];
  assign len_clamp = (req.code_length > LenW'(MAX_CODE_BITS)) ? LenW'(MAX_CODE_BITS)
                                                               : req.code_length;
  assign ram_we    = accept && (req.mode == MODE_LOAD) && in_range;
  assign ram_re    = accept && (req.mode == MODE_ENCODE);
  assign ram_wdata = {req.code_bits[MAX_CODE_BITS-1:0], len_clamp[SLW-1:0]};

  hbp_ram #(.WIDTH(RAMW), .DEPTH(SYMBOLS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Length reads as zero until the entry is loaded; out-of-range symbols too.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      loaded_q <= 1'b0;
    end else begin
      if (ram_we) begin
        loaded[addr] <= 1'b1;
      end
      if (ram_re) begin
        loaded_q <= in_range && loaded[addr];
      end
    end
  end

  assign lk_len  = loaded_q ? LenW'(ram_rdata[SLW-1:0]) : '0;
  assign lk_code = loaded_q ? CodeW'(ram_rdata[RAMW-1:SLW]) : '0;

  hbp_packer u_packer (
    .clk  (clk),
    .rst  (rst),
    .ctl  (pctl),
    .code (lk_code),
    .len  (lk_len),
    .stat (pstat)
  );

  assign out_free = !out_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.mode == MODE_ENCODE) begin
          state_next = ST_LOOKUP;
        end else if (accept && req.mode == MODE_FLUSH) begin
          state_next = ST_FLUSH;
        end
      end
      ST_LOOKUP: state_next = ST_EMIT;
      ST_EMIT: begin
        if (pstat.remaining == 3'd0) begin
          state_next = ST_IDLE;
        end else if (out_free && pstat.remaining == 3'd1) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready    = 1'b0;
    pctl         = '0;
    out_load     = 1'b0;
    out_byte_d   = pstat.head;
    byte_valid_d = 1'b1;
    total_d      = '0;
    last_d       = (pstat.remaining == 3'd1);
    case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_LOOKUP: pctl.start = 1'b1;
      ST_EMIT: begin
        if (pstat.remaining != 3'd0 && out_free) begin
          pctl.step = 1'b1;
          out_load  = 1'b1;
        end
      end
      ST_FLUSH: begin
        out_byte_d   = pstat.pending;
        byte_valid_d = (pstat.pending_count != 3'd0);
        total_d      = counter;
        last_d       = 1'b1;
        if (out_free) begin
          pctl.clear = 1'b1;
          out_load   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      counter <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOOKUP && counter != '1) begin
        counter <= counter + TotalW'(1);
      end else if (state == ST_FLUSH && out_free) begin
        counter <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte     <= out_byte_d;
      byte_valid   <= byte_valid_d;
      symbol_total <= total_d;
      last         <= last_d;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.out_byte     = out_byte;
  assign rsp.byte_valid   = byte_valid;
  assign rsp.symbol_total = symbol_total;
  assign rsp.last         = last;

  a_out_from_emit_or_flush: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT || $past(state) == ST_FLUSH))
    else $error("result item loaded outside emit/flush");

  a_flush_clears_bits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && out_free) |=> (pstat.pending_count == 3'd0 && counter == '0))
    else $error("flush left pending bits or count");

  a_emit_counts_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && pstat.remaining != 3'd0 && out_free)
      |=> (pstat.remaining == $past(pstat.remaining) - 3'd1))
    else $error("byte countdown slipped");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP || state == ST_EMIT) |-> !req.ready)
    else $error("input taken during encode");

endmodule

`default_nettype wire

@@ test/huffman_bit_packer_unit_tb.sv @@
// Testbench for huffman_bit_packer_unit: sends load, encode and flush items,
// predicts the packed output bytes and flush counts, and checks every result item.
// Depends on hbp_pkg, hbp_if and the design sources.

module huffman_bit_packer_unit_tb;
  import hbp_pkg::*;

  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam int               TABLE_SIZE = 256;
  localparam logic [LenW-1:0]  LONGEST_CODE = 6'd32;
  localparam int               DRAIN_CYCLES = 40;
  localparam int               HOLD_CYCLES = 400;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              byte_valid;
    logic [TotalW-1:0] symbol_total;
    logic              last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst;

  hbp_in_if  req_if ();
  hbp_out_if rsp_if ();

  huffman_bit_packer_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #5 clk = ~clk;

  // code table mirror and bit accumulator
  logic [CodeW-1:0]  tab_code [TABLE_SIZE];
  logic [LenW-1:0]   tab_len [TABLE_SIZE];
  logic              tab_written [TABLE_SIZE];
  logic [SymW-1:0]   loaded_syms [$];
  logic [ByteW-1:0]  acc_byte;
  int                acc_count;
  logic [TotalW-1:0] symbols_seen;
  packed_byte_t      bytes_due [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int errors = 0;
  int results_checked = 0;
  int loads_sent = 0;
  int encodes_sent = 0;
  int flushes_sent = 0;
  int ignored_sent = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h (result %0d)", field, got, want,
             results_checked);
    errors++;
  endtask

  // Applies one accepted item to the mirror state and queues the bytes it packs.
  function automatic void encode_into_bytes(input logic [ModeW-1:0] mode,
                                            input logic [SymW-1:0] sym,
                                            input logic [CodeW-1:0] code,
                                            input logic [LenW-1:0] len);
    packed_byte_t     item;
    logic [CodeW-1:0] word;
    int               nbits;
    item = '0;
    case (mode)
      MODE_LOAD: begin
        tab_code[sym] = code;
        tab_len[sym] = (len > LONGEST_CODE) ? LONGEST_CODE : len;
        if (!tab_written[sym]) loaded_syms.push_back(sym);
        tab_written[sym] = 1'b1;
      end
      MODE_ENCODE: begin
        word = tab_code[sym];
        nbits = int'(tab_len[sym]);
        for (int i = nbits; i > 0; i--) begin
          acc_byte = {acc_byte[ByteW-2:0], word[i-1]};
          acc_count++;
          if (acc_count == ByteW) begin
            item.out_byte = acc_byte;
            item.byte_valid = 1'b1;
            item.symbol_total = '0;
            // another byte completes only if a full byte of code bits remains
            item.last = (i <= ByteW);
            bytes_due.push_back(item);
            acc_byte = '0;
            acc_count = 0;
          end
        end
        if (symbols_seen != '1) symbols_seen++;
      end
      MODE_FLUSH: begin
        item.out_byte = acc_byte << (ByteW - acc_count);
        item.byte_valid = (acc_count != 0);
        item.symbol_total = symbols_seen;
        item.last = 1'b1;
        bytes_due.push_back(item);
        acc_byte = '0;
        acc_count = 0;
        symbols_seen = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the item.
  task automatic send_item(input logic [ModeW-1:0] mode, input logic [SymW-1:0] sym,
                           input logic [CodeW-1:0] code, input logic [LenW-1:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= mode;
    req_if.symbol      <= sym;
    req_if.code_bits   <= code;
    req_if.code_length <= len;
    do @(posedge clk); while (!req_if.ready);
    encode_into_bytes(mode, sym, code, len);
    case (mode)
      MODE_LOAD:   loads_sent++;
      MODE_ENCODE: encodes_sent++;
      MODE_FLUSH:  flushes_sent++;
      default:     ignored_sent++;
    endcase
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Output side: random stalls, plus a long hold when the pressure test asks.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    packed_byte_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (bytes_due.size() == 0) begin
        report_mismatch("result with none expected", rsp_if.out_byte, 32'd0);
      end else begin
        want = bytes_due.pop_front();
        results_checked++;
        if (rsp_if.out_byte !== want.out_byte)
          report_mismatch("out_byte", rsp_if.out_byte, want.out_byte);
        if (rsp_if.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", rsp_if.byte_valid, want.byte_valid);
        if (rsp_if.symbol_total !== want.symbol_total)
          report_mismatch("symbol_total", rsp_if.symbol_total, want.symbol_total);
        if (rsp_if.last !== want.last)
          report_mismatch("last", rsp_if.last, want.last);
      end
    end
  end

  // Longest code, one-bit code, zero length, overlong length, stray high bits.
  task automatic test_table_extremes();
    send_item(MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    send_item(MODE_LOAD, 8'hFF, 32'h0000_0000, 6'd1);
    send_item(MODE_LOAD, 8'h01, 32'h0000_00A5, 6'd0);
    send_item(MODE_LOAD, 8'h02, 32'h8000_0001, 6'd63);
    send_item(MODE_LOAD, 8'h55, 32'hDEAD_BEE5, 6'd3);
    send_item(MODE_LOAD, 8'hAA, 32'h0000_003C, 6'd8);
    send_item(MODE_ENCODE, 8'h00, '0, '0);
    send_item(MODE_ENCODE, 8'hFF, '0, '0);
    send_item(MODE_ENCODE, 8'h55, '0, '0);
    send_item(MODE_FLUSH, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_flush_cases();
    send_item(MODE_FLUSH, '0, '0, '0);
    // zero-length code still counts as a symbol
    send_item(MODE_ENCODE, 8'h01, '0, '0);
    // never-loaded symbol: counts, emits nothing
    send_item(MODE_ENCODE, 8'h7E, '0, '0);
    send_item(MODE_FLUSH, '0, '0, '0);
    send_item(MODE_ENCODE, 8'hAA, '0, '0);
    // 1 + 32 bits: four bytes out, one bit left pending
    send_item(MODE_ENCODE, 8'hFF, '0, '0);
    send_item(MODE_ENCODE, 8'h02, '0, '0);
    send_item(MODE_FLUSH, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_ignored_mode();
    send_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_item(MODE_ENCODE, 8'h55, '0, '0);
    send_item(MODE_FLUSH, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_items, input int idle, input int stall);
    int              sent;
    int              pick;
    logic [LenW-1:0] len;
    logic [SymW-1:0] sym;
    send_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        pick = $urandom_range(99);
        if (pick < 10) len = '0;
        else if (pick < 20) len = LenW'($urandom_range(63, 33));
        else if (pick < 50) len = LenW'($urandom_range(8, 1));
        else len = LenW'($urandom_range(32, 1));
        send_item(MODE_LOAD, SymW'($urandom_range(255)), $urandom(), len);
        sent++;
      end else if (pick < 84) begin
        // mostly loaded symbols, now and then any byte value
        if ($urandom_range(3) == 0) sym = SymW'($urandom_range(255));
        else sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        send_item(MODE_ENCODE, sym, $urandom(), LenW'($urandom()));
        sent++;
      end else if (pick < 95) begin
        send_item(MODE_FLUSH, SymW'($urandom()), $urandom(), LenW'($urandom()));
        sent++;
      end else begin
        send_item(MODE_UNUSED, SymW'($urandom()), $urandom(), LenW'($urandom()));
      end
    end
    drain_results();
  endtask

  // Output held off while encodes keep coming, so the input side must stall.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    hold_request = HOLD_CYCLES;
    repeat (22) send_item(MODE_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                          '0, '0);
    send_item(MODE_ENCODE, 8'h00, '0, '0);
    send_item(MODE_FLUSH, '0, '0, '0);
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.mode = MODE_LOAD;
    req_if.symbol = '0;
    req_if.code_bits = '0;
    req_if.code_length = '0;
    rsp_if.ready = 1'b0;
    acc_byte = '0;
    acc_count = 0;
    symbols_seen = '0;
    for (int s = 0; s < TABLE_SIZE; s++) begin
      tab_code[s] = '0;
      tab_len[s] = '0;
      tab_written[s] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_table_extremes();
    test_flush_cases();
    test_ignored_mode();
    test_random_traffic(55, 0, 0);
    test_random_traffic(55, 81, 0);
    test_random_traffic(55, 0, 81);
    test_random_traffic(55, 25, 25);
    test_output_backpressure();

    stall_pct = 0;
    drain_results();
    $display("Sent %0d loads, %0d encodes, %0d flushes, %0d ignored items; %0d results checked",
             loads_sent, encodes_sent, flushes_sent, ignored_sent, results_checked);
    $display("Traffic ran free, with sender gaps, receiver stalls, both, and a long output hold");
    if (errors == 0) begin
      $display("huffman_bit_packer_unit verification clean");
    end else begin
      $display("huffman_bit_packer_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", bytes_due.size());
    $display("huffman_bit_packer_unit verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/hbp_pkg.sv
design/hbp_if.sv
design/hbp_ram.sv
design/hbp_packer.sv
design/huffman_bit_packer_unit.sv
test/huffman_bit_packer_unit_tb.sv
